// ===== rtl/core/htbd_pkg.sv =====
// ---------------------------------------------------------------------------
// htbd_pkg
// Shared types and constants of the Huffman tree-walk bit decoder.
// ---------------------------------------------------------------------------
package htbd_pkg;

    localparam int MAX_NODES   = 512;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int SLOT_W      = 9;
    localparam int SYMBOL_BITS = 8;
    localparam int COUNT_W     = 32;
    localparam int OP_W        = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic REG_ROOT     = 1'b0;
    localparam logic REG_EXPECTED = 1'b1;

    typedef struct packed {
        logic                   left_present;
        logic [SLOT_W-1:0]      left_slot;
        logic                   right_present;
        logic [SLOT_W-1:0]      right_slot;
        logic [SYMBOL_BITS-1:0] symbol;
    } node_entry_t;

    typedef struct packed {
        logic mem_we;    // store the node entry of the accepted request
        logic restart;   // return walk to root, clear the symbol count
        logic load_bit;  // capture the code bit of a decode request
        logic step;      // take one edge of the tree
        logic check;     // finish the step: leaf test and walk update
        logic hold;      // keep the reached node's entry on the read port
        logic emit;      // load the output register with a symbol
    } htbd_cmd_t;

    typedef struct packed {
        logic ignore;    // symbol count already reached
        logic leaf;      // reached node has no children
        logic out_free;  // output register can take a symbol
    } htbd_status_t;

endpackage

// ===== rtl/core/htbd_dpath.sv =====
// ---------------------------------------------------------------------------
// htbd_dpath
// Node table memory, walk position, symbol count and output register.
// ---------------------------------------------------------------------------
module htbd_dpath import htbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  htbd_cmd_t              cmd,
    output htbd_status_t           status,
    input  logic [SLOT_W-1:0]      node_slot,
    input  logic                   left_present,
    input  logic [SLOT_W-1:0]      left_slot,
    input  logic                   right_present,
    input  logic [SLOT_W-1:0]      right_slot,
    input  logic [SYMBOL_BITS-1:0] leaf_symbol,
    input  logic                   code_bit,
    input  logic [SLOT_W-1:0]      root_node,
    input  logic [COUNT_W-1:0]     expected_symbols,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [SYMBOL_BITS-1:0] m_symbol_out,
    output logic                   m_final_symbol
);

    node_entry_t            node_mem [MAX_NODES];
    node_entry_t            rd_entry_reg;
    node_entry_t            wr_entry;
    logic [NODE_AW-1:0]     rd_addr;

    logic [SLOT_W-1:0]      current_reg, current_next;
    logic [SLOT_W-1:0]      next_reg;
    logic [SLOT_W-1:0]      step_slot;
    logic                   code_bit_reg;
    logic [COUNT_W-1:0]     total_reg, total_next, total_plus;
    logic                   leaf;

    logic                   out_valid_reg;
    logic [SYMBOL_BITS-1:0] out_symbol_reg;
    logic                   out_final_reg;

    assign wr_entry = '{left_present:  left_present,
                        left_slot:     left_slot,
                        right_present: right_present,
                        right_slot:    right_slot,
                        symbol:        leaf_symbol};

    // Simple dual-port table: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            node_mem[node_slot[NODE_AW-1:0]] <= wr_entry;
        end
        rd_entry_reg <= node_mem[rd_addr];
    end

    // Child selection from the current node's entry
    always_comb begin
        if (rd_entry_reg.left_present && rd_entry_reg.right_present) begin
            step_slot = code_bit_reg ? rd_entry_reg.right_slot : rd_entry_reg.left_slot;
        end else if (rd_entry_reg.left_present) begin
            step_slot = rd_entry_reg.left_slot;
        end else if (rd_entry_reg.right_present) begin
            step_slot = rd_entry_reg.right_slot;
        end else begin
            step_slot = current_reg;
        end
    end

    assign leaf       = !rd_entry_reg.left_present && !rd_entry_reg.right_present;
    assign total_plus = total_reg + COUNT_W'(1);

    always_comb begin
        if (cmd.restart) begin
            current_next = root_node;
        end else if (cmd.check) begin
            current_next = leaf ? root_node : next_reg;
        end else begin
            current_next = current_reg;
        end
    end

    always_comb begin
        if (cmd.restart) begin
            total_next = '0;
        end else if (cmd.emit) begin
            total_next = total_plus;
        end else begin
            total_next = total_reg;
        end
    end

    always_comb begin
        if (cmd.step) begin
            rd_addr = step_slot[NODE_AW-1:0];
        end else if (cmd.hold) begin
            rd_addr = next_reg[NODE_AW-1:0];
        end else begin
            rd_addr = current_next[NODE_AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg <= '0;
            total_reg   <= '0;
        end else begin
            current_reg <= current_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_bit) begin
            code_bit_reg <= code_bit;
        end
        if (cmd.step) begin
            next_reg <= step_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_symbol_reg <= rd_entry_reg.symbol;
            out_final_reg  <= (total_plus == expected_symbols);
        end
    end

    assign status.ignore   = (total_reg >= expected_symbols);
    assign status.leaf     = leaf;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid        = out_valid_reg;
    assign m_symbol_out   = out_symbol_reg;
    assign m_final_symbol = out_final_reg;

endmodule

// ===== rtl/core/htbd_ctrl.sv =====
// ---------------------------------------------------------------------------
// htbd_ctrl
// Sequencer for one decode request: step through the table, then leaf check.
// ---------------------------------------------------------------------------
module htbd_ctrl import htbd_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] s_operation,
    output logic            s_ready,
    input  htbd_status_t    status,
    output htbd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_STEP  = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   can_finish;
    logic   accept;
    logic   take_decode;

    // A stalled leaf waits for the output register; inner nodes never stall
    assign can_finish  = !status.leaf || status.out_free;
    assign s_ready     = (state_reg == ST_IDLE) || ((state_reg == ST_CHECK) && can_finish);
    assign accept      = s_valid && s_ready;
    assign take_decode = accept && (s_operation == OP_DECODE);

    always_comb begin
        cmd          = '0;
        cmd.mem_we   = accept && (s_operation == OP_WRITE);
        cmd.restart  = accept && (s_operation == OP_RESTART);
        cmd.load_bit = take_decode;
        cmd.step     = (state_reg == ST_STEP) && !status.ignore;
        cmd.check    = (state_reg == ST_CHECK) && can_finish;
        cmd.hold     = (state_reg == ST_CHECK) && !can_finish;
        cmd.emit     = (state_reg == ST_CHECK) && can_finish && status.leaf;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_decode) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = status.ignore ? ST_IDLE : ST_CHECK;
            end
            ST_CHECK: begin
                if (can_finish) begin
                    state_next = take_decode ? ST_STEP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/huffman_tree_bit_decoder.sv =====
// ---------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Huffman decoder that walks a loaded node table one code bit per request.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_valid/s_ready    table write, code bit or restart
//  m_*       out        m_valid/m_ready    decoded symbol and last-symbol flag
//  APB       in/out     psel/penable       root_node (0x0), expected_symbols (0x4)
//
//  A decode request reads the current node's entry from the table at
//  acceptance and the chosen child's entry in the step cycle, and the leaf
//  check overlaps acceptance of the next request. Both reads go through the
//  table's single registered read port. A bit past the expected count
//  changes nothing. Reset is synchronous and clears the walk, the count and
//  the registers; the table holds whatever was last written.
//  A leaf holds the decoder while the output register is full and not taken.
// ---------------------------------------------------------------------------
module huffman_tree_bit_decoder import htbd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [SLOT_W-1:0]      s_node_slot,
    input  logic                   s_left_present,
    input  logic [SLOT_W-1:0]      s_left_slot,
    input  logic                   s_right_present,
    input  logic [SLOT_W-1:0]      s_right_slot,
    input  logic [SYMBOL_BITS-1:0] s_leaf_symbol,
    input  logic                   s_code_bit,
    // symbol channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SYMBOL_BITS-1:0] m_symbol_out,
    output logic                   m_final_symbol,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    htbd_cmd_t          cmd;
    htbd_status_t       status;
    logic [SLOT_W-1:0]  root_reg;
    logic [COUNT_W-1:0] expected_reg;
    logic               reg_write;
    logic               reg_sel;

    // Registers are word spaced; decode on the word index only
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg     <= '0;
            expected_reg <= '0;
        end else if (reg_write) begin
            if (reg_sel == REG_ROOT) begin
                root_reg <= pwdata[SLOT_W-1:0];
            end else begin
                expected_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_EXPECTED) begin
            prdata = expected_reg;
        end else begin
            prdata = {{(APB_DW-SLOT_W){1'b0}}, root_reg};
        end
    end

    // Sequencer: owns the request handshake and issues one command set a cycle
    htbd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: node table, walk position, count and output register
    htbd_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .node_slot        (s_node_slot),
        .left_present     (s_left_present),
        .left_slot        (s_left_slot),
        .right_present    (s_right_present),
        .right_slot       (s_right_slot),
        .leaf_symbol      (s_leaf_symbol),
        .code_bit         (s_code_bit),
        .root_node        (root_reg),
        .expected_symbols (expected_reg),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_symbol_out     (m_symbol_out),
        .m_final_symbol   (m_final_symbol)
    );

endmodule

// ===== rtl/core/htbd_checker.sv =====
// ---------------------------------------------------------------------------
// htbd_checker
// Port-level assertions for the Huffman tree-walk bit decoder.
// ---------------------------------------------------------------------------
module htbd_checker import htbd_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [OP_W-1:0]        s_operation,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SYMBOL_BITS-1:0] m_symbol_out,
    input logic                   m_final_symbol
);

    // Symbol held while the consumer stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol_out) && $stable(m_final_symbol))
        else $error("symbol changed or dropped while stalled");

    // Reset leaves no symbol pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("symbol pending after reset");

    // Write, restart and unused requests never produce a symbol
    a_no_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation != OP_DECODE) |=> ##1 !$rose(m_valid))
        else $error("symbol produced by a non-decode request");

    // A decode request occupies the step cycle
    a_decode_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == OP_DECODE) |=> !s_ready)
        else $error("request taken during the step cycle");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_operation    (s_operation),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_symbol_out   (m_symbol_out),
    .m_final_symbol (m_final_symbol)
);
